@@ rtl/dts_pkg.sv @@
// ============================================================================
// dts_pkg - shared types and constants for the dependency sort core
// Field structs, command/status bundles between controller and datapath.
// ============================================================================
package dts_pkg;

   localparam int NODES   = 64;
   localparam int DEPS    = 8;
   localparam int NODE_W  = 6;                      // node index width
   localparam int CNT_W   = 4;                      // 0 .. DEPS edge count
   localparam int DEP_AW  = 3;                      // edge slot index width
   localparam int ADJ_AW  = NODE_W + DEP_AW;        // adjacency address
   localparam int TOP_W   = NODE_W + 1;             // 0 .. NODES
   localparam int COUNT_W = 7;                      // node_count register

   // request function codes
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_SORT  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // result status codes
   localparam logic [1:0] ST_ORDER = 2'd0;
   localparam logic [1:0] ST_CYCLE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // visit marks
   localparam logic [1:0] MARK_NEW  = 2'd0;
   localparam logic [1:0] MARK_OPEN = 2'd1;
   localparam logic [1:0] MARK_DONE = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [NODE_W-1:0] target_node;
      logic [NODE_W-1:0] dep_node;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [NODE_W-1:0] order_node;
      logic              last;
   } rsp_type;

   // where the result node field comes from
   typedef enum logic [1:0] {
      RSRC_ORDER,
      RSRC_DEP,
      RSRC_TARGET,
      RSRC_ZERO
   } rsp_src_type;

   typedef struct packed {
      logic        latch;        // capture request, reset walk counters
      logic        clear_deps;   // drop every dependency list
      logic        add_write;    // append edge to current node
      logic        clr_step;     // one step of the visit mark sweep
      logic        root_next;    // advance root index
      logic        frame_root;   // open a walk at the current root
      logic        mark_rd_dep;  // look up mark of the edge just read
      logic        idx_inc;      // consume one edge of the current frame
      logic        push;         // descend into the dependency
      logic        finish;       // close current frame, append to order
      logic        pop_load;     // resume parent frame from stack
      logic        out_next;     // advance order readout
      logic        rsp_load;     // load result register
      logic [1:0]  rsp_status;
      rsp_src_type rsp_src;
      logic        rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       count_zero;
      logic       cnt_full;
      logic       idx_lt_cnt;
      logic       d_out;
      logic [1:0] mark;
      logic       top_one;
      logic       r_last;
      logic       k_last;
      logic       clr_last;
      logic       out_free;
   } dp_stat_type;

endpackage

@@ rtl/dts_ctrl.sv @@
// ============================================================================
// dts_ctrl - sequencer for the dependency sort core
// Steps edge appends, list clears, the mark sweep, the depth-first walk and the readout.
// ============================================================================
module dts_ctrl
   import dts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_ADD_RD,
      S_ADD_CHK,
      S_FULL,
      S_EMPTY,
      S_CLR,
      S_ROOT_RD,
      S_ROOT_CHK,
      S_FRAME_RD,
      S_FRAME_CHK,
      S_MARK_CHK,
      S_POP_RD,
      S_POP_LD,
      S_CYCLE,
      S_OUT_RD,
      S_OUT_WR
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_src = RSRC_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.func)
               FUNC_ADD:   state_in = S_ADD_RD;
               FUNC_SORT:  state_in = stat.count_zero ? S_EMPTY : S_CLR;
               FUNC_CLEAR: begin
                  cmd.clear_deps = 1'b1;
                  state_in       = S_IDLE;
               end
               default:    state_in = S_IDLE;
            endcase
         end
         S_ADD_RD: state_in = S_ADD_CHK;
         S_ADD_CHK: begin
            if (stat.cnt_full) begin
               state_in = S_FULL;
            end else begin
               cmd.add_write = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FULL: begin
            if (stat.out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_FULL;
               cmd.rsp_src    = RSRC_TARGET;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (stat.out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_EMPTY;
               cmd.rsp_src    = RSRC_ZERO;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_ROOT_RD;
            end
         end
         S_ROOT_RD: state_in = S_ROOT_CHK;
         S_ROOT_CHK: begin
            if (stat.mark != MARK_NEW) begin
               if (stat.r_last) begin
                  state_in = S_OUT_RD;
               end else begin
                  cmd.root_next = 1'b1;
                  state_in      = S_ROOT_RD;
               end
            end else begin
               cmd.frame_root = 1'b1;
               state_in       = S_FRAME_RD;
            end
         end
         S_FRAME_RD: state_in = S_FRAME_CHK;
         S_FRAME_CHK: begin
            if (stat.idx_lt_cnt) begin
               cmd.idx_inc = 1'b1;
               if (stat.d_out) begin
                  state_in = S_FRAME_RD;
               end else begin
                  cmd.mark_rd_dep = 1'b1;
                  state_in        = S_MARK_CHK;
               end
            end else begin
               cmd.finish = 1'b1;
               if (!stat.top_one) begin
                  state_in = S_POP_RD;
               end else if (stat.r_last) begin
                  state_in = S_OUT_RD;
               end else begin
                  cmd.root_next = 1'b1;
                  state_in      = S_ROOT_RD;
               end
            end
         end
         S_MARK_CHK: begin
            if (stat.mark == MARK_OPEN) begin
               state_in = S_CYCLE;
            end else if (stat.mark == MARK_NEW) begin
               cmd.push = 1'b1;
               state_in = S_FRAME_RD;
            end else begin
               state_in = S_FRAME_RD;
            end
         end
         S_POP_RD: state_in = S_POP_LD;
         S_POP_LD: begin
            cmd.pop_load = 1'b1;
            state_in     = S_FRAME_RD;
         end
         S_CYCLE: begin
            if (stat.out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_CYCLE;
               cmd.rsp_src    = RSRC_DEP;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_OUT_RD: state_in = S_OUT_WR;
         S_OUT_WR: begin
            if (stat.out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_ORDER;
               cmd.rsp_src    = RSRC_ORDER;
               cmd.rsp_last   = stat.k_last;
               if (stat.k_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = S_OUT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ rtl/dts_datapath.sv @@
// ============================================================================
// dts_datapath - tables, walk registers and result register
// Dependency lists, visit marks, frame stack and order buffer memories.
// ============================================================================
module dts_datapath
   import dts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  logic               csr_valid,
   input  logic [COUNT_W-1:0] csr_data,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   // configuration
   logic [COUNT_W-1:0] node_count_ff;
   logic [COUNT_W-1:0] count_sat;

   // request and walk registers
   logic [1:0]        func_ff;
   logic [NODE_W-1:0] dep_in_ff;
   logic [NODE_W-1:0] cur_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [NODE_W-1:0] d_ff;
   logic [TOP_W-1:0]  top_ff;
   logic [NODE_W-1:0] r_ff;
   logic [TOP_W-1:0]  n_ff;
   logic [NODE_W-1:0] k_ff;
   logic [NODE_W-1:0] clr_ptr_ff;

   // memories
   logic [CNT_W-1:0]          depc_mem [NODES];
   logic [NODES-1:0]          depc_valid_ff;
   logic [NODE_W-1:0]         adj_mem  [NODES*DEPS];
   logic [1:0]                mark_mem [NODES];
   logic [NODE_W+CNT_W-1:0]   stk_mem  [NODES];
   logic [NODE_W-1:0]         ord_mem  [NODES];

   logic [CNT_W-1:0]        depc_q;
   logic                    depc_vq;
   logic [NODE_W-1:0]       adj_q;
   logic [1:0]              mark_q;
   logic [NODE_W+CNT_W-1:0] stk_q;
   logic [NODE_W-1:0]       ord_q;

   logic [CNT_W-1:0]        cnt_eff;
   logic [ADJ_AW-1:0]       adj_rd_addr;
   logic [ADJ_AW-1:0]       adj_wr_addr;
   logic [NODE_W-1:0]       mark_rd_addr;
   logic                    mark_we;
   logic [NODE_W-1:0]       mark_wr_addr;
   logic [1:0]              mark_wr_data;
   logic [TOP_W-1:0]        top_m1;
   logic [NODE_W-1:0]       stk_addr;
   logic [TOP_W-1:0]        n_m1;
   logic [COUNT_W-1:0]      count_m1;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    out_free;

   assign count_sat = (node_count_ff > COUNT_W'(NODES)) ? COUNT_W'(NODES) : node_count_ff;
   assign count_m1  = count_sat - COUNT_W'(1);
   assign cnt_eff   = depc_vq ? depc_q : '0;
   assign top_m1    = top_ff - TOP_W'(1);
   assign stk_addr  = top_m1[NODE_W-1:0];
   assign n_m1      = n_ff - TOP_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign adj_rd_addr  = {cur_ff, idx_ff[DEP_AW-1:0]};
   assign adj_wr_addr  = {cur_ff, cnt_eff[DEP_AW-1:0]};
   assign mark_rd_addr = cmd.mark_rd_dep ? adj_q : r_ff;

   always_comb begin
      mark_we      = 1'b1;
      mark_wr_addr = clr_ptr_ff;
      mark_wr_data = MARK_NEW;
      if (cmd.frame_root) begin
         mark_wr_addr = r_ff;
         mark_wr_data = MARK_OPEN;
      end else if (cmd.push) begin
         mark_wr_addr = d_ff;
         mark_wr_data = MARK_OPEN;
      end else if (cmd.finish) begin
         mark_wr_addr = cur_ff;
         mark_wr_data = MARK_DONE;
      end else if (!cmd.clr_step) begin
         mark_we = 1'b0;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         depc_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            node_count_ff <= csr_data;
         end
         if (cmd.clear_deps) begin
            depc_valid_ff <= '0;
         end else if (cmd.add_write) begin
            depc_valid_ff[cur_ff] <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- walk registers ----------------
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff    <= req_data.func;
         cur_ff     <= req_data.target_node;
         dep_in_ff  <= req_data.dep_node;
         clr_ptr_ff <= '0;
         r_ff       <= '0;
         n_ff       <= '0;
         k_ff       <= '0;
      end
      if (cmd.clr_step) begin
         clr_ptr_ff <= clr_ptr_ff + NODE_W'(1);
      end
      if (cmd.root_next) begin
         r_ff <= r_ff + NODE_W'(1);
      end
      if (cmd.frame_root) begin
         cur_ff <= r_ff;
         idx_ff <= '0;
         top_ff <= TOP_W'(1);
      end
      if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CNT_W'(1);
         d_ff   <= adj_q;
      end
      if (cmd.push) begin
         cur_ff <= d_ff;
         idx_ff <= '0;
         top_ff <= top_ff + TOP_W'(1);
      end
      if (cmd.finish) begin
         n_ff   <= n_ff + TOP_W'(1);
         top_ff <= top_m1;
      end
      if (cmd.pop_load) begin
         cur_ff <= stk_q[NODE_W+CNT_W-1:CNT_W];
         idx_ff <= stk_q[CNT_W-1:0];
      end
      if (cmd.out_next) begin
         k_ff <= k_ff + NODE_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_ff.status <= cmd.rsp_status;
         rsp_ff.last   <= cmd.rsp_last;
         unique case (cmd.rsp_src)
            RSRC_ORDER:  rsp_ff.order_node <= ord_q;
            RSRC_DEP:    rsp_ff.order_node <= d_ff;
            RSRC_TARGET: rsp_ff.order_node <= cur_ff;
            default:     rsp_ff.order_node <= '0;
         endcase
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         depc_mem[cur_ff] <= cnt_eff + CNT_W'(1);
      end
      depc_q  <= depc_mem[cur_ff];
      depc_vq <= depc_valid_ff[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         adj_mem[adj_wr_addr] <= dep_in_ff;
      end
      adj_q <= adj_mem[adj_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wr_addr] <= mark_wr_data;
      end
      mark_q <= mark_mem[mark_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stk_mem[stk_addr] <= {cur_ff, idx_ff};
      end
      stk_q <= stk_mem[stk_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         ord_mem[n_ff[NODE_W-1:0]] <= cur_ff;
      end
      ord_q <= ord_mem[k_ff];
   end

   // ---------------- status to controller ----------------
   always_comb begin
      stat.func       = func_ff;
      stat.count_zero = (count_sat == '0);
      stat.cnt_full   = (cnt_eff >= CNT_W'(DEPS));
      stat.idx_lt_cnt = (idx_ff < cnt_eff);
      stat.d_out      = ({1'b0, adj_q} >= count_sat);
      stat.mark       = mark_q;
      stat.top_one    = (top_ff == TOP_W'(1));
      stat.r_last     = ({1'b0, r_ff} == count_m1);
      stat.k_last     = ({1'b0, k_ff} == n_m1);
      stat.clr_last   = (clr_ptr_ff == NODE_W'(NODES - 1));
      stat.out_free   = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/dependency_topo_sort_core.sv @@
// ============================================================================
// dependency_topo_sort_core - depth-first topological sort with cycle check
// Holds per-node dependency lists, sorts on command, streams the order.
// ============================================================================
//
//   channel  | direction | handshake          | contents
//   ---------+-----------+--------------------+---------------------------------
//   req_*    | in        | req_valid/req_stall| func, target_node, dep_node
//   rsp_*    | out       | rsp_valid/rsp_stall| status, order_node, last
//   csr_*    | in        | csr_valid/csr_ready| node_count (7 bits)
//
// Sort flow: the visit marks are swept, each root is probed, each edge is read
//   and checked, each node is closed, then the order is streamed out; the
//   registered reads of the mark and adjacency memories set one walk step per
//   read-then-check pair.
// Reset: dependency counts sit behind per-node valid bits, so the block is
//   ready right after reset; the visit marks are swept at every non-empty sort.
// Stalls: results sit in an output register; rsp_stall only holds the
//   sequencer when a new result is ready and the register is still full.
//   req_stall is high while a request is in progress.
//
module dependency_topo_sort_core
   import dts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // requests
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   // results
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   // node_count register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   dts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   dts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
